FILE: design/assert_macros.svh
// assertion macros shared by the design files
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define DEQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// implication: antecedent at one edge, consequent at the next edge
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk, rstn, prop, msg)
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: design/deq_pkg.sv
// shared types and constants of the double-ended queue
// no dependencies; used by deq_cell and double_ended_queue_top
package deq_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned FillW        = 5;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4,
    FUNC_PEEK_BACK  = 3'd5,
    FUNC_EMPTY_TEST = 3'd6
  } deq_func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             push_front;
    logic             push_back;
    logic             pop_front;
    logic             pop_back;
    logic [DataW-1:0] value;
  } deq_ctrl_t;

endpackage

FILE: design/deq_cell.sv
// one storage cell of the deque chain: a word and its valid bit
// depends on deq_pkg
module deq_cell import deq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  deq_ctrl_t        ctrl_i,
  input  logic [DataW-1:0] prev_word_i,
  input  logic             prev_valid_i,
  input  logic [DataW-1:0] next_word_i,
  input  logic             next_valid_i,
  output logic [DataW-1:0] word_o,
  output logic             valid_o,
  output logic [DataW-1:0] last_word_o
);

  logic [DataW-1:0] word_q, word_d;
  logic             valid_q, valid_d;
  logic             last;

  // last occupied cell of the row
  assign last = valid_q & ~next_valid_i;

  always_comb begin
    word_d  = word_q;
    valid_d = valid_q;
    if (ctrl_i.push_front) begin
      word_d  = prev_word_i;
      valid_d = prev_valid_i;
    end else if (ctrl_i.pop_front) begin
      word_d  = next_word_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.push_back) begin
      if (!valid_q && prev_valid_i) begin
        word_d  = ctrl_i.value;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.pop_back) begin
      if (last) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o      = word_q;
  assign valid_o     = valid_q;
  assign last_word_o = last ? word_q : '0;

endmodule

FILE: design/double_ended_queue_top.sv
// top level of the double-ended queue: chain of deq_cell, control and result register
// depends on deq_pkg, deq_cell and assert_macros.svh
//
// bounded double-ended queue of signed 32-bit words, DEPTH entries deep. a
// transaction is accepted on a rising edge with start high and busy low;
// busy is always low, so a new operation can be issued in every cycle. the
// result of each transaction appears in the cycle after acceptance, on the
// result ports for exactly one cycle, marked by result_valid_o; the receiver
// cannot stall, so it must take every result in that cycle. the entries live
// in a row of cells with the front entry always in cell 0: push front and
// pop front shift the whole row by one cell, push back fills the first
// free cell and pop back frees the last occupied one. the back entry is
// found by each cell flagging whether it is the last occupied one, so no
// operation has to search the row, whatever the fill level. a pop or
// peek on an empty queue reports status empty and data zero, a push into a
// full queue is refused with status full; in both cases the contents stay
// as they were. fill_count_o carries the low five bits of the entry count.
`include "assert_macros.svh"

module double_ended_queue_top import deq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              func_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    result_valid_o,
  output logic signed [DataW-1:0] data_o,
  output logic [1:0]              status_o,
  output logic                    empty_flag_o,
  output logic [FillW-1:0]        fill_count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // entry count and its derived flags
  logic [CntW-1:0] count_q, count_d;
  logic            is_empty, is_full;
  logic            accept;

  // cell row
  deq_ctrl_t        ctrl;
  logic [DataW-1:0] cell_word  [DEPTH];
  logic [DataW-1:0] cell_last  [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DataW-1:0] back_word;

  // result register
  logic             res_valid_q;
  logic [DataW-1:0] res_data_q, res_data_d;
  deq_status_e      res_status_q, res_status_d;
  logic             res_empty_q;
  logic [FillW-1:0] res_fill_q;

  // the block never holds off a transaction, so busy is tied low
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(DEPTH));

  // decode the transaction into cell control and the next count / result
  always_comb begin
    ctrl         = '0;
    ctrl.value   = value_i;
    count_d      = count_q;
    res_data_d   = '0;
    res_status_d = ST_OK;
    if (accept) begin
      case (deq_func_e'(func_i))
        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
          if (is_full) begin
            res_status_d = ST_FULL;
          end else begin
            ctrl.push_front = (deq_func_e'(func_i) == FUNC_PUSH_FRONT);
            ctrl.push_back  = (deq_func_e'(func_i) == FUNC_PUSH_BACK);
            count_d         = count_q + CntW'(1);
          end
        end
        FUNC_POP_FRONT, FUNC_PEEK_FRONT: begin
          if (is_empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_data_d = cell_word[0];
            if (deq_func_e'(func_i) == FUNC_POP_FRONT) begin
              ctrl.pop_front = 1'b1;
              count_d        = count_q - CntW'(1);
            end
          end
        end
        FUNC_POP_BACK, FUNC_PEEK_BACK: begin
          if (is_empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_data_d = back_word;
            if (deq_func_e'(func_i) == FUNC_POP_BACK) begin
              ctrl.pop_back = 1'b1;
              count_d       = count_q - CntW'(1);
            end
          end
        end
        default: begin
          // empty test and unused codes leave the queue alone
        end
      endcase
    end
  end

  // row of cells: cell 0 holds the front, neighbours pass words on a shift
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DataW-1:0] prev_word, next_word;
    logic             prev_valid, next_valid;

    if (k == 0) begin : g_first
      // the incoming word enters cell 0 on a push front
      assign prev_word  = value_i;
      assign prev_valid = 1'b1;
    end else begin : g_inner_prev
      assign prev_word  = cell_word[k-1];
      assign prev_valid = cell_valid[k-1];
    end

    if (k == DEPTH - 1) begin : g_final
      assign next_word  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner_next
      assign next_word  = cell_word[k+1];
      assign next_valid = cell_valid[k+1];
    end

    deq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_word_i  (prev_word),
      .prev_valid_i (prev_valid),
      .next_word_i  (next_word),
      .next_valid_i (next_valid),
      .word_o       (cell_word[k]),
      .valid_o      (cell_valid[k]),
      .last_word_o  (cell_last[k])
    );
  end

  // only the last occupied cell drives a non-zero word, so an or picks the back
  always_comb begin
    back_word = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      back_word = back_word | cell_last[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= accept;
    end
  end

  // result payload, meaningful only while result_valid_o is high
  always_ff @(posedge clk_i) begin
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    res_empty_q  <= (count_d == '0);
    res_fill_q   <= FillW'(count_d);
  end

  assign result_valid_o = res_valid_q;
  assign data_o         = res_data_q;
  assign status_o       = res_status_q;
  assign empty_flag_o   = res_empty_q;
  assign fill_count_o   = res_fill_q;

  // occupied cells always form an unbroken run starting at cell 0
  `DEQ_ASSERT(a_valid_contiguous, clk_i, rst_ni, ((cell_valid & (cell_valid + 1'b1)) == '0), "occupied cells not contiguous")
  // entry count agrees with the number of occupied cells
  `DEQ_ASSERT(a_count_matches, clk_i, rst_ni, ($countones(cell_valid) == int'(count_q)), "entry count out of step with cells")
  // every accepted transaction yields a result in the following cycle
  `DEQ_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, accept, result_valid_o, "result strobe missing")
  // a full report is only given when the queue is at capacity
  `DEQ_ASSERT_NEXT(a_full_only_at_cap, clk_i, rst_ni, (accept && !is_full), (status_o != ST_FULL), "push refused below capacity")

endmodule
